// File: rtl/core/lcs_length_ratio_top_macros.svh
// Assertion macros for the lcs_length_ratio top level.
// Expects clk and rst (active high) in the scope of every use.
`ifndef LCS_LENGTH_RATIO_TOP_MACROS_SVH
`define LCS_LENGTH_RATIO_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LCSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LCSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lcsr_pkg.sv
// Shared types and constants of the lcs_length_ratio block.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps
package lcsr_pkg;

  // Item kinds on the command port.
  typedef enum logic [1:0] {
    KIND_A   = 2'd0,
    KIND_B   = 2'd1,
    KIND_FIN = 2'd2
  } kind_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  // Field widths of the result item and of the divider step counter.
  localparam int LEN_W     = 7;
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(Q_BITS + 1);

endpackage

// File: rtl/core/lcsr_cell.sv
// One systolic DP cell: holds one a symbol and its DP value.
// No package dependencies; instantiated in a row by lcs_length_ratio_top.
`timescale 1ns / 1ps
module lcsr_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int SYM_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             a_wr,
  input  logic [CNT_W-1:0] a_count,
  input  logic [SYM_W-1:0] a_sym_in,
  input  logic             in_valid,
  input  logic [SYM_W-1:0] in_sym,
  input  logic [CNT_W-1:0] in_up,
  input  logic [CNT_W-1:0] in_diag,
  input  logic [CNT_W-1:0] in_lcs,
  output logic             out_valid,
  output logic [SYM_W-1:0] out_sym,
  output logic [CNT_W-1:0] out_up,
  output logic [CNT_W-1:0] out_diag,
  output logic [CNT_W-1:0] out_lcs
);

  logic [SYM_W-1:0] a_sym;
  logic [CNT_W-1:0] dp;
  logic [CNT_W-1:0] cell_val;
  logic             is_last;

  // This cell holds the final a symbol when the count points just past it
  assign is_last = (a_count == CNT_W'(IDX + 1));

  // DP update: diagonal plus one on a match, else the larger neighbor
  always_comb begin
    if (in_sym == a_sym) begin
      cell_val = in_diag + CNT_W'(1);
    end else if (dp > in_up) begin
      cell_val = dp;
    end else begin
      cell_val = in_up;
    end
  end

  // Capture the a symbol addressed to this cell
  always_ff @(posedge clk) begin
    if (a_wr && (a_count == CNT_W'(IDX))) begin
      a_sym <= a_sym_in;
    end
  end

  // Advance the wavefront; pick up the LCS at the final cell
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_valid <= 1'b0;
      dp        <= '0;
      out_lcs   <= '0;
    end else begin
      out_valid <= in_valid;
      if (in_valid) begin
        dp      <= cell_val;
        out_lcs <= is_last ? cell_val : in_lcs;
      end
    end
  end

  // Hand symbol, new value and old value to the next cell
  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_sym  <= in_sym;
      out_up   <= cell_val;
      out_diag <= dp;
    end
  end

endmodule

// File: rtl/core/lcsr_div.sv
// Restoring divider for the Q1.16 ratio, one quotient bit per cycle.
// Depends on lcsr_pkg for the quotient and step-counter widths.
`timescale 1ns / 1ps
module lcsr_div #(
  parameter int CNT_W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [CNT_W-1:0]          dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic [lcsr_pkg::Q_BITS-1:0] quotient
);
  import lcsr_pkg::*;

  logic [CNT_W:0]      rem;
  logic [CNT_W-1:0]    div_r;
  logic [STEP_W-1:0]   step;
  logic                running;
  logic                ge;
  logic [CNT_W:0]      rem_sub;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    ge      = (rem >= {1'b0, div_r});
    rem_sub = ge ? (rem - {1'b0, div_r}) : rem;
  end

  // Sequence the quotient steps
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(Q_BITS);
      end else if (running) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Shift the remainder and collect quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      div_r    <= divisor;
      quotient <= '0;
    end else if (running) begin
      rem      <= {rem_sub[CNT_W-1:0], 1'b0};
      quotient <= {quotient[Q_BITS-2:0], ge};
    end
  end

endmodule

// File: rtl/core/lcs_length_ratio_top.sv
// Top level of lcs_length_ratio: command port, systolic cell row, divider.
// Depends on lcsr_pkg, lcsr_cell, lcsr_div and lcs_length_ratio_top_macros.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   command  | start, busy        | kind, symbol
//   result   | done (one cycle)   | lcs_len, shorter_length, ratio_q16,
//            |                    | empty_flag, overflow_flag
//
// Append and b items may follow back to back; each b
// symbol runs down the cell row as a wavefront, one cell per cycle.
// A finish item waits until the last wavefront has left the row, then the
// radix-2 divider runs 17 quotient steps; done rises once the divider has
// finished, and busy drops in that same cycle.
// Reset is synchronous and takes effect at once; no clearing pass is needed.
// The result cannot be stalled: done is high for exactly one cycle.
`timescale 1ns / 1ps
`include "lcs_length_ratio_top_macros.svh"
module lcs_length_ratio_top #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  symbol,
  output logic        done,
  output logic [6:0]  lcs_len,
  output logic [6:0]  shorter_length,
  output logic [16:0] ratio_q16,
  output logic        empty_flag,
  output logic        overflow_flag
);
  import lcsr_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SYM_W = SYMBOL_BITS;

  state_t             state;
  logic [CNT_W-1:0]   a_count;
  logic [15:0]        b_count;
  logic               overflowed;
  logic [CNT_W-1:0]   drain_cnt;
  logic [CNT_W-1:0]   lcs_r;
  logic [CNT_W-1:0]   shorter_r;

  logic               accept;
  logic               a_item;
  logic               a_wr;
  logic               b_go;
  logic               fin;
  logic               drain_end;
  logic               clear_all;
  logic [SYM_W-1:0]   sym_in;
  logic [CNT_W-1:0]   shorter;
  logic               div_done;
  logic [Q_BITS-1:0]  quotient;

  // Wavefront links between neighboring cells
  logic               link_valid [0:MAX_LEN];
  logic [CNT_W-1:0]   link_lcs   [0:MAX_LEN];
  logic [SYM_W-1:0]   link_sym   [0:MAX_LEN-1];
  logic [CNT_W-1:0]   link_up    [0:MAX_LEN-1];
  logic [CNT_W-1:0]   link_diag  [0:MAX_LEN-1];

  // Decode accepted items
  always_comb begin
    accept = start && !busy;
    a_item = accept && (kind == KIND_A);
    a_wr   = a_item && (b_count == 16'd0) && (a_count < CNT_W'(MAX_LEN));
    b_go   = accept && (kind == KIND_B);
    fin    = accept && (kind == KIND_FIN);
  end

  assign busy      = (state != ST_IDLE);
  assign sym_in    = SYM_W'(symbol);
  assign drain_end = (state == ST_DRAIN) && (drain_cnt == '0);
  assign clear_all = (state == ST_DIV) && div_done;

  // Shorter of the two lengths; b fits the count width when it is the smaller
  assign shorter = (b_count >= 16'(a_count)) ? a_count : b_count[CNT_W-1:0];

  // Feed the head of the row
  assign link_valid[0] = b_go;
  assign link_sym[0]   = sym_in;
  assign link_up[0]    = '0;
  assign link_diag[0]  = '0;
  assign link_lcs[0]   = '0;

  // Build the cell row
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    if (g < MAX_LEN - 1) begin : g_mid
      lcsr_cell #(.IDX(g), .CNT_W(CNT_W), .SYM_W(SYM_W)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (clear_all),
        .a_wr     (a_wr),
        .a_count  (a_count),
        .a_sym_in (sym_in),
        .in_valid (link_valid[g]),
        .in_sym   (link_sym[g]),
        .in_up    (link_up[g]),
        .in_diag  (link_diag[g]),
        .in_lcs   (link_lcs[g]),
        .out_valid(link_valid[g+1]),
        .out_sym  (link_sym[g+1]),
        .out_up   (link_up[g+1]),
        .out_diag (link_diag[g+1]),
        .out_lcs  (link_lcs[g+1])
      );
    end else begin : g_end
      lcsr_cell #(.IDX(g), .CNT_W(CNT_W), .SYM_W(SYM_W)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (clear_all),
        .a_wr     (a_wr),
        .a_count  (a_count),
        .a_sym_in (sym_in),
        .in_valid (link_valid[g]),
        .in_sym   (link_sym[g]),
        .in_up    (link_up[g]),
        .in_diag  (link_diag[g]),
        .in_lcs   (link_lcs[g]),
        .out_valid(link_valid[g+1]),
        .out_sym  (),
        .out_up   (),
        .out_diag (),
        .out_lcs  (link_lcs[g+1])
      );
    end
  end

  // Ratio divider, started once the row has drained
  lcsr_div #(.CNT_W(CNT_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (drain_end),
    .dividend(link_lcs[MAX_LEN]),
    .divisor (shorter),
    .done    (div_done),
    .quotient(quotient)
  );

  // Sequence items, counts and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      a_count    <= '0;
      b_count    <= '0;
      overflowed <= 1'b0;
      drain_cnt  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (b_go) begin
        drain_cnt <= CNT_W'(MAX_LEN - 1);
      end else if (drain_cnt != '0) begin
        drain_cnt <= drain_cnt - CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (a_wr) begin
            a_count <= a_count + CNT_W'(1);
          end
          if (a_item && !a_wr) begin
            overflowed <= 1'b1;
          end
          if (b_go && (b_count != 16'hFFFF)) begin
            b_count <= b_count + 16'd1;
          end
          if (fin) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            done       <= 1'b1;
            a_count    <= '0;
            b_count    <= '0;
            overflowed <= 1'b0;
            drain_cnt  <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the drained LCS and the shorter length for the result fields
  always_ff @(posedge clk) begin
    if (drain_end) begin
      lcs_r     <= link_lcs[MAX_LEN];
      shorter_r <= shorter;
    end
  end

  // Drive the result fields
  always_ff @(posedge clk) begin
    if (clear_all) begin
      lcs_len        <= LEN_W'(lcs_r);
      shorter_length <= LEN_W'(shorter_r);
      ratio_q16      <= (shorter_r == '0) ? '0 : quotient;
      empty_flag     <= (shorter_r == '0);
      overflow_flag  <= overflowed;
    end
  end

  // The result cycle starts from cleared counts
  `LCSR_ASSERT_SAME(a_done_cleared, done,
    (a_count == '0) && (b_count == 16'd0) && !overflowed,
    "state not cleared after result")
  // A finish item blocks further items on the next cycle
  `LCSR_ASSERT_NEXT(a_fin_busy, fin, busy, "finish item did not raise busy")
  // A wavefront started by a b item reaches the end of the row
  `LCSR_ASSERT_SAME(a_wave_drain, b_go, ##MAX_LEN link_valid[MAX_LEN],
    "wavefront lost in cell row")
  // The LCS never exceeds the shorter length
  `LCSR_ASSERT_SAME(a_lcs_bound, done, lcs_r <= shorter_r,
    "lcs exceeds shorter length")
  // No b item is accepted while the divider is being started
  `LCSR_ASSERT_SAME(a_drain_quiet, drain_end, !b_go,
    "b item accepted during drain")

endmodule
